// ----- src/lrt_pkg.sv -----
package lrt_pkg;

  // Fixed field and datapath widths
  localparam int FEAT_W   = 16;   // Q4.12 feature
  localparam int WEIGHT_W = 32;   // Q8.24 weight
  localparam int GRAD_W   = 48;   // gradient sum, saturating
  localparam int Z_W      = 53;   // exact dot product, Q.36
  localparam int ERR_W    = 26;   // prediction error, Q0.24
  localparam int SIG_W    = 25;   // sigmoid value incl. 1.0
  localparam int NF_W     = 5;
  localparam int BS_W     = 9;
  localparam int EP_W     = 16;
  localparam int LR_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  // Shared multiplier operand widths
  localparam int MUL_A_W = 48;
  localparam int MUL_B_W = 17;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // Update divider: |g*lr| >> 28 divided by batch length
  localparam int DIV_SHIFT = 28;
  localparam int DIV_N_W   = MUL_P_W - DIV_SHIFT;
  localparam int DIV_D_W   = 9;

  localparam logic [SIG_W-1:0] ONE_Q24 = SIG_W'(1) << 24;
  localparam logic signed [FEAT_W-1:0] ONE_Q12 = 16'sd4096;
  localparam int MAX_BATCH = 256;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUM_FEATURES  = 2'd0,
    CFG_BATCH_SIZE    = 2'd1,
    CFG_EPOCHS        = 2'd2,
    CFG_LEARNING_RATE = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic start;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ----- src/lrt_ram.sv -----
module lrt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // One write port, registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- src/lrt_mul.sv -----
module lrt_mul import lrt_pkg::*; (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic signed [MUL_A_W-1:0] a_i,
  input  logic signed [MUL_B_W-1:0] b_i,
  output logic signed [MUL_P_W-1:0] p_o
);

  // Shared signed multiplier, product registered
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_o <= a_i * b_i;
    end
  end

endmodule

// ----- src/lrt_div.sv -----
module lrt_div import lrt_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  div_ctrl_t          ctrl_i,
  input  logic [DIV_N_W-1:0] dividend_i,
  input  logic [DIV_D_W-1:0] divisor_i,
  output div_stat_t          stat_o,
  output logic [DIV_N_W-1:0] quotient_o
);

  localparam int CNT_W = $clog2(DIV_N_W + 1);

  logic [DIV_N_W-1:0] n_q;
  logic [DIV_D_W-1:0] d_q;
  logic [DIV_D_W-1:0] rem_q;
  logic [CNT_W-1:0]   cnt_q;
  logic               busy_q;
  logic               done_q;
  logic [DIV_D_W:0]   rem_sh;
  logic               ge;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  assign rem_sh = {rem_q, n_q[DIV_N_W-1]};
  assign ge     = rem_sh >= {1'b0, d_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (ctrl_i.start) begin
      n_q    <= dividend_i;
      d_q    <= divisor_i;
      rem_q  <= '0;
      cnt_q  <= CNT_W'(DIV_N_W);
      busy_q <= 1'b1;
      done_q <= 1'b0;
    end else if (busy_q) begin
      rem_q  <= ge ? DIV_D_W'(rem_sh - {1'b0, d_q}) : DIV_D_W'(rem_sh);
      n_q    <= {n_q[DIV_N_W-2:0], ge};
      cnt_q  <= cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quotient_o  = n_q;

endmodule

// ----- src/lrt_sigmoid.sv -----
module lrt_sigmoid import lrt_pkg::*; #(
  parameter int DEPTH = 256
) (
  input  logic                    clk_i,
  input  logic signed [Z_W-1:0]   z_i,
  input  logic                    label_i,
  output logic signed [ERR_W-1:0] err_o
);

  localparam int TW = $clog2(DEPTH);
  localparam logic [63:0] H_STEP = (64'd8 << 32) / DEPTH;
  localparam logic [TW:0] DEPTH_C = (TW + 1)'(DEPTH);

  typedef logic [23:0] tab_t [DEPTH];

  // Long division for building the table at elaboration
  function automatic logic [63:0] udiv64(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] r;
    logic [63:0] q;
    int k;
    r = '0;
    q = '0;
    for (k = 63; k >= 0; k--) begin
      r = {r[63:0], a[k]};
      if (r >= {1'b0, b}) begin
        r = r - {1'b0, b};
        q[k] = 1'b1;
      end
    end
    return q;
  endfunction

  // sigmoid(k*h) in Q0.24, with e^-h from a Taylor series
  function automatic tab_t build_table();
    tab_t t;
    logic [63:0] r;
    logic [63:0] term;
    logic [63:0] p;
    logic [63:0] den;
    int n;
    int k;
    r    = 64'h1_0000_0000;
    term = 64'h1_0000_0000;
    p    = 64'h1_0000_0000;
    for (n = 1; n <= 12; n++) begin
      term = udiv64((term * H_STEP) >> 32, 64'(n));
      if (n[0]) r = r - term;
      else      r = r + term;
    end
    for (k = 0; k < DEPTH; k++) begin
      den  = 64'h1_0000_0000 + p;
      t[k] = 24'(udiv64((64'd1 << 56) + (den >> 1), den));
      p    = (p * r) >> 32;
    end
    return t;
  endfunction

  localparam tab_t SIG_TABLE = build_table();

  logic [Z_W-1:0]    mag;
  logic              sat;
  logic [39+TW:0]    prod;
  logic [TW-1:0]     idx;
  logic [SIG_W-1:0]  s_pos;
  logic [SIG_W-1:0]  s_val;

  // Table lookup on |z|, saturating at 8.0, mirrored for negative z
  always_comb begin
    mag   = z_i[Z_W-1] ? Z_W'(-z_i) : Z_W'(z_i);
    sat   = |mag[Z_W-1:39];
    prod  = mag[38:0] * DEPTH_C;
    idx   = prod[39 +: TW];
    s_pos = sat ? ONE_Q24 : {1'b0, SIG_TABLE[idx]};
    s_val = z_i[Z_W-1] ? ONE_Q24 - s_pos : s_pos;
  end

  always_ff @(posedge clk_i) begin
    err_o <= $signed({1'b0, s_val}) - (label_i ? $signed({1'b0, ONE_Q24}) : ERR_W'(0));
  end

endmodule

// ----- src/logistic_regression_minibatch_trainer.sv -----
// Loading: one feature value per cycle, tready held high while loading.
// Training after set_end: per sample a dot product, sigmoid and gradient pass; per batch a
// weight update by the shared multiplier and bit-serial divider. nf+1 weights then leave
// one per cycle while m_axis_tready is high; input stalls from set_end until the last is taken.
// Reset clears weights, counters and registers to their defaults; the sample and label
// memories hold nothing valid until loaded.
module logistic_regression_minibatch_trainer import lrt_pkg::*; #(
  parameter int MAX_FEATURES        = 16,
  parameter int MAX_SAMPLES         = 2048,
  parameter int SIGMOID_TABLE_DEPTH = 256
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration write channel
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]               cfg_index_i,
  input  logic [CFG_DATA_W-1:0]              cfg_data_i,
  // input stream
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [FEAT_W-1:0]                  s_axis_tdata,  // [15:0] feature_value
  input  logic [1:0]                         s_axis_tuser,  // [0] is_target, [1] row_end
  input  logic                               s_axis_tlast,  // set_end
  // result stream
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [WEIGHT_W-1:0]                m_axis_tdata,  // [31:0] weight_value
  output logic [$clog2(MAX_FEATURES+1)-1:0]  m_axis_tuser,  // weight_index
  output logic                               m_axis_tlast   // last_weight
);

  localparam int JW     = $clog2(MAX_FEATURES + 1);
  localparam int FIW    = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
  localparam int SIW    = $clog2(MAX_SAMPLES);
  localparam int CW     = $clog2(MAX_SAMPLES + 1);
  localparam int SDEPTH = MAX_SAMPLES * (2 ** FIW);
  localparam int SAW    = SIW + FIW;

  typedef enum logic [3:0] {
    S_LOAD, S_EPOCH, S_BATCH,
    S_ZRD, S_ZMUL, S_ZACC, S_SIG,
    S_GRD, S_GMUL, S_GACC,
    S_UMUL, S_UDIV, S_UWAIT, S_UW,
    S_OUT
  } state_e;

  state_e state_q;

  // Configuration registers
  logic [NF_W-1:0] cfg_nf_q;
  logic [BS_W-1:0] cfg_bs_q;
  logic [EP_W-1:0] cfg_ep_q;
  logic [LR_W-1:0] cfg_lr_q;

  // Training registers latched at set_end
  logic [JW-1:0]   nf_q;
  logic [BS_W-1:0] bs_q;
  logic [EP_W-1:0] ep_q;
  logic [LR_W-1:0] lr_q;
  logic [CW-1:0]   m_q;

  logic [JW-1:0]   fpos_q;
  logic [CW-1:0]   cnt_q;
  logic [EP_W-1:0] ep_cnt_q;
  logic [CW-1:0]   start_q;
  logic [CW-1:0]   end_q;
  logic [BS_W-1:0] cur_q;
  logic [CW-1:0]   i_q;
  logic [JW-1:0]   j_q;
  logic            neg_q;

  logic signed [Z_W-1:0]      z_q;
  logic signed [WEIGHT_W-1:0] w_q [MAX_FEATURES+1];
  logic signed [GRAD_W-1:0]   g_q [MAX_FEATURES+1];

  logic [JW-1:0]   nf_eff;
  logic [BS_W-1:0] bs_eff;
  logic            in_acc;
  logic            out_acc;
  logic            row_end;
  logic            has_room;
  logic [CW-1:0]   cnt_next;

  logic            samp_we;
  logic            lab_we;
  logic [SAW-1:0]  samp_waddr;
  logic [SAW-1:0]  samp_raddr;
  logic [JW-1:0]   jm1;
  logic [FEAT_W-1:0] feat_rd;
  logic            lab_rd;

  logic signed [FEAT_W-1:0]  x_sel;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic                      mul_en;
  logic signed [MUL_P_W-1:0] mul_q;
  logic signed [ERR_W-1:0]   err;

  div_ctrl_t          div_ctrl;
  div_stat_t          div_stat;
  logic [MUL_P_W-1:0] prod_mag;
  logic [DIV_N_W-1:0] quot;

  logic [CW-1:0]             rem_cnt;
  logic [BS_W-1:0]           cur_w;
  logic signed [GRAD_W+1:0]  gsum;
  logic signed [GRAD_W-1:0]  gsat;
  logic signed [WEIGHT_W+7:0] delta;
  logic signed [WEIGHT_W+7:0] wsum;
  logic signed [WEIGHT_W-1:0] wsat;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == S_LOAD);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = (state_q == S_OUT);
  assign out_acc       = m_axis_tvalid && m_axis_tready;
  assign m_axis_tdata  = w_q[j_q];
  assign m_axis_tuser  = j_q;
  assign m_axis_tlast  = (j_q == nf_q);

  // Register values brought into their working range
  always_comb begin
    if (cfg_nf_q == '0) begin
      nf_eff = JW'(1);
    end else if (32'(cfg_nf_q) > MAX_FEATURES) begin
      nf_eff = JW'(MAX_FEATURES);
    end else begin
      nf_eff = JW'(cfg_nf_q);
    end
    if (cfg_bs_q == '0) begin
      bs_eff = BS_W'(1);
    end else if (32'(cfg_bs_q) > MAX_BATCH) begin
      bs_eff = BS_W'(MAX_BATCH);
    end else begin
      bs_eff = cfg_bs_q;
    end
  end

  // Loader: store writes and sample count
  assign row_end    = s_axis_tuser[1] | s_axis_tlast;
  assign has_room   = (32'(cnt_q) < MAX_SAMPLES);
  assign samp_we    = in_acc && (fpos_q < nf_eff) && has_room;
  assign lab_we     = in_acc && row_end && has_room;
  assign samp_waddr = {cnt_q[SIW-1:0], fpos_q[FIW-1:0]};
  assign cnt_next   = lab_we ? cnt_q + CW'(1) : cnt_q;

  assign jm1        = j_q - JW'(1);
  assign samp_raddr = {i_q[SIW-1:0], jm1[FIW-1:0]};

  lrt_ram #(.WIDTH(FEAT_W), .DEPTH(SDEPTH)) u_sample_ram (
    .clk_i   (clk_i),
    .we_i    (samp_we),
    .waddr_i (samp_waddr),
    .wdata_i (s_axis_tdata),
    .raddr_i (samp_raddr),
    .rdata_o (feat_rd)
  );

  lrt_ram #(.WIDTH(1), .DEPTH(MAX_SAMPLES)) u_label_ram (
    .clk_i   (clk_i),
    .we_i    (lab_we),
    .waddr_i (cnt_q[SIW-1:0]),
    .wdata_i (s_axis_tuser[0]),
    .raddr_i (i_q[SIW-1:0]),
    .rdata_o (lab_rd)
  );

  // Operand selection for the shared multiplier
  assign x_sel = (j_q == '0) ? ONE_Q12 : $signed(feat_rd);

  always_comb begin
    mul_a  = MUL_A_W'(w_q[j_q]);
    mul_b  = MUL_B_W'(x_sel);
    mul_en = 1'b0;
    unique case (state_q)
      S_ZMUL: begin
        mul_en = 1'b1;
      end
      S_GMUL: begin
        mul_a  = MUL_A_W'(err);
        mul_en = 1'b1;
      end
      S_UMUL: begin
        mul_a  = g_q[j_q];
        mul_b  = $signed({1'b0, lr_q});
        mul_en = 1'b1;
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  lrt_mul u_mul (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_q)
  );

  lrt_sigmoid #(.DEPTH(SIGMOID_TABLE_DEPTH)) u_sigmoid (
    .clk_i   (clk_i),
    .z_i     (z_q),
    .label_i (lab_rd),
    .err_o   (err)
  );

  // Update divider: |g*lr| >> 28 over the batch length
  assign prod_mag       = mul_q[MUL_P_W-1] ? MUL_P_W'(-mul_q) : MUL_P_W'(mul_q);
  assign div_ctrl.start = (state_q == S_UDIV);

  lrt_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (div_ctrl),
    .dividend_i (prod_mag[MUL_P_W-1:DIV_SHIFT]),
    .divisor_i  (cur_q),
    .stat_o     (div_stat),
    .quotient_o (quot)
  );

  // Batch length, saturating gradient sum, saturating weight update
  always_comb begin
    rem_cnt = m_q - start_q;
    cur_w   = (17'(rem_cnt) > 17'(bs_q)) ? bs_q : BS_W'(rem_cnt);
    gsum    = (GRAD_W + 2)'(g_q[j_q]) + $signed(mul_q[GRAD_W+1:0]);
    if (gsum > $signed({3'b000, {(GRAD_W-1){1'b1}}})) begin
      gsat = {1'b0, {(GRAD_W-1){1'b1}}};
    end else if (gsum < $signed({3'b111, {(GRAD_W-1){1'b0}}})) begin
      gsat = {1'b1, {(GRAD_W-1){1'b0}}};
    end else begin
      gsat = gsum[GRAD_W-1:0];
    end
    delta = neg_q ? -$signed((WEIGHT_W + 8)'(quot)) : $signed((WEIGHT_W + 8)'(quot));
    wsum  = (WEIGHT_W + 8)'(w_q[j_q]) - delta;
    if (wsum > $signed({9'h000, {(WEIGHT_W-1){1'b1}}})) begin
      wsat = {1'b0, {(WEIGHT_W-1){1'b1}}};
    end else if (wsum < $signed({9'h1FF, {(WEIGHT_W-1){1'b0}}})) begin
      wsat = {1'b1, {(WEIGHT_W-1){1'b0}}};
    end else begin
      wsat = wsum[WEIGHT_W-1:0];
    end
  end

  // Sequencer with loader, configuration and weight state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_LOAD;
      cfg_nf_q <= NF_W'(13);
      cfg_bs_q <= BS_W'(32);
      cfg_ep_q <= EP_W'(1000);
      cfg_lr_q <= LR_W'(6554);
      nf_q     <= '0;
      bs_q     <= '0;
      ep_q     <= '0;
      lr_q     <= '0;
      m_q      <= '0;
      fpos_q   <= '0;
      cnt_q    <= '0;
      ep_cnt_q <= '0;
      start_q  <= '0;
      end_q    <= '0;
      cur_q    <= '0;
      i_q      <= '0;
      j_q      <= '0;
      neg_q    <= 1'b0;
      z_q      <= '0;
      for (int k = 0; k <= MAX_FEATURES; k++) begin
        w_q[k] <= '0;
        g_q[k] <= '0;
      end
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_idx_e'(cfg_index_i))
          CFG_NUM_FEATURES:  cfg_nf_q <= cfg_data_i[NF_W-1:0];
          CFG_BATCH_SIZE:    cfg_bs_q <= cfg_data_i[BS_W-1:0];
          CFG_EPOCHS:        cfg_ep_q <= cfg_data_i[EP_W-1:0];
          CFG_LEARNING_RATE: cfg_lr_q <= cfg_data_i[LR_W-1:0];
        endcase
      end

      unique case (state_q)
        S_LOAD: begin
          if (in_acc) begin
            if (row_end) begin
              fpos_q <= '0;
            end else if (fpos_q < nf_eff) begin
              fpos_q <= fpos_q + JW'(1);
            end
            if (s_axis_tlast) begin
              nf_q     <= nf_eff;
              bs_q     <= bs_eff;
              ep_q     <= cfg_ep_q;
              lr_q     <= cfg_lr_q;
              m_q      <= cnt_next;
              cnt_q    <= '0;
              ep_cnt_q <= '0;
              for (int k = 0; k <= MAX_FEATURES; k++) begin
                w_q[k] <= '0;
              end
              state_q  <= S_EPOCH;
            end else if (row_end) begin
              cnt_q <= cnt_next;
            end
          end
        end
        S_EPOCH: begin
          if (ep_cnt_q == ep_q) begin
            j_q     <= '0;
            state_q <= S_OUT;
          end else begin
            start_q <= '0;
            state_q <= S_BATCH;
          end
        end
        S_BATCH: begin
          if (start_q >= m_q) begin
            ep_cnt_q <= ep_cnt_q + EP_W'(1);
            state_q  <= S_EPOCH;
          end else begin
            cur_q <= cur_w;
            end_q <= start_q + CW'(cur_w);
            i_q   <= start_q;
            j_q   <= '0;
            z_q   <= '0;
            for (int k = 0; k <= MAX_FEATURES; k++) begin
              g_q[k] <= '0;
            end
            state_q <= S_ZRD;
          end
        end
        // dot product: bias then features
        S_ZRD:  state_q <= S_ZMUL;
        S_ZMUL: state_q <= S_ZACC;
        S_ZACC: begin
          z_q <= z_q + $signed(mul_q[Z_W-1:0]);
          if (j_q == nf_q) begin
            state_q <= S_SIG;
          end else begin
            j_q     <= j_q + JW'(1);
            state_q <= S_ZRD;
          end
        end
        S_SIG: begin
          j_q     <= '0;
          state_q <= S_GRD;
        end
        // gradient accumulation
        S_GRD:  state_q <= S_GMUL;
        S_GMUL: state_q <= S_GACC;
        S_GACC: begin
          g_q[j_q] <= gsat;
          if (j_q == nf_q) begin
            j_q <= '0;
            if (i_q + CW'(1) == end_q) begin
              state_q <= S_UMUL;
            end else begin
              i_q     <= i_q + CW'(1);
              z_q     <= '0;
              state_q <= S_ZRD;
            end
          end else begin
            j_q     <= j_q + JW'(1);
            state_q <= S_GRD;
          end
        end
        // weight update, one weight at a time
        S_UMUL: state_q <= S_UDIV;
        S_UDIV: begin
          neg_q   <= mul_q[MUL_P_W-1];
          state_q <= S_UWAIT;
        end
        S_UWAIT: begin
          if (div_stat.done) begin
            state_q <= S_UW;
          end
        end
        S_UW: begin
          w_q[j_q] <= wsat;
          if (j_q == nf_q) begin
            start_q <= end_q;
            state_q <= S_BATCH;
          end else begin
            j_q     <= j_q + JW'(1);
            state_q <= S_UMUL;
          end
        end
        S_OUT: begin
          if (out_acc) begin
            if (j_q == nf_q) begin
              j_q     <= '0;
              state_q <= S_LOAD;
            end else begin
              j_q <= j_q + JW'(1);
            end
          end
        end
        default: state_q <= S_LOAD;
      endcase
    end
  end

endmodule
